// ===== hw/rtl/gne_pkg.sv =====
// Shared constants, payload types and helper functions for the grid neighbor expansion block.
package gne_pkg;

	localparam int MAX_WIDTH     = 64;
	localparam int MAX_HEIGHT    = 64;
	localparam int WEIGHT_BITS   = 24;
	localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
	localparam int ENTRY_BITS    = WEIGHT_BITS + 1;
	localparam int NODE_BITS     = 12;
	localparam int WEIGHT_IN_BITS = 24;
	localparam int DIM_BITS      = 7;
	localparam int X_BITS        = $clog2(MAX_WIDTH);
	localparam int Y_BITS        = $clog2(MAX_HEIGHT);
	localparam int COORD_BITS    = DIM_BITS + 1;
	localparam int COST_BITS     = 32;
	localparam int FACTOR_BITS   = 16;
	localparam int PROD_BITS     = WEIGHT_BITS + FACTOR_BITS;
	localparam int FRAC_BITS     = 8;
	localparam int MODE_BITS     = 2;
	localparam int NUM_DIRS      = 8;
	localparam int DIR_BITS      = $clog2(NUM_DIRS);
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_EXPAND = 1'b1
	} op_t;

	localparam logic [MODE_BITS-1:0] DIAG_NONE   = 2'd0;
	localparam logic [MODE_BITS-1:0] DIAG_BOTH   = 2'd1;
	localparam logic [MODE_BITS-1:0] DIAG_EITHER = 2'd2;
	localparam logic [MODE_BITS-1:0] DIAG_ALWAYS = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIAGONAL_MODE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WRAP_HORIZ    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WRAP_VERT     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIAG_FACTOR   = 3'd5;

	typedef struct packed {
		op_t                       op;
		logic [NODE_BITS-1:0]      node;
		logic [WEIGHT_IN_BITS-1:0] weight_in;
		logic                      obstacle_in;
		logic                      reversed;
	} req_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] neighbor;
		logic [COST_BITS-1:0] edge_cost;
		logic                 empty_res;
		logic                 last;
	} res_t;

	// Order: top, bottom, left, right, up-left, up-right, down-left, down-right.
	function automatic logic signed [1:0] step_dx(input logic [DIR_BITS-1:0] d);
		logic signed [1:0] v;
		unique case (d)
			3'd2, 3'd4, 3'd6: v = -2'sd1;
			3'd3, 3'd5, 3'd7: v = 2'sd1;
			default:          v = 2'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [1:0] step_dy(input logic [DIR_BITS-1:0] d);
		logic signed [1:0] v;
		unique case (d)
			3'd0, 3'd4, 3'd5: v = -2'sd1;
			3'd1, 3'd6, 3'd7: v = 2'sd1;
			default:          v = 2'sd0;
		endcase
		return v;
	endfunction

	// Round half up to the fraction point, saturate to the cost width.
	function automatic logic [COST_BITS-1:0] round_cost(input logic [PROD_BITS-1:0] prod);
		logic [PROD_BITS:0]           sum;
		logic [PROD_BITS-FRAC_BITS:0] shifted;
		sum     = {1'b0, prod} + (PROD_BITS+1)'(1 << (FRAC_BITS - 1));
		shifted = sum[PROD_BITS:FRAC_BITS];
		if (|shifted[PROD_BITS-FRAC_BITS:COST_BITS]) begin
			return '1;
		end
		return shifted[COST_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/gne_store.sv =====
// Cell weight store: one write port, one read port with registered read data.
module gne_store
	import gne_pkg::*;
(
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_BITS-1:0]  waddr,
	input  logic [ENTRY_BITS-1:0] wdata,
	input  logic                  re,
	input  logic [ADDR_BITS-1:0]  raddr,
	output logic [ENTRY_BITS-1:0] rdata
);

	logic [ENTRY_BITS-1:0] mem [STORE_DEPTH];
	logic [ENTRY_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the last read until the next one
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/gne_div.sv =====
// Restoring divider, one quotient bit per cycle: splits a node index into row and column.
module gne_div
	import gne_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NODE_BITS-1:0] dividend,
	input  logic [DIM_BITS-1:0]  divisor,
	output logic                 busy,
	output logic [NODE_BITS-1:0] quot,
	output logic [DIM_BITS-1:0]  rem
);

	localparam int CNT_BITS = $clog2(NODE_BITS + 1);

	logic                 busy_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [NODE_BITS-1:0] quot_q;
	logic [DIM_BITS-1:0]  rem_q;
	logic [DIM_BITS-1:0]  div_q;

	logic [DIM_BITS:0]    trial;
	logic                 fits;
	logic [DIM_BITS-1:0]  rem_next;

	always_comb begin
		trial    = {rem_q, quot_q[NODE_BITS-1]};
		fits     = trial >= {1'b0, div_q};
		rem_next = fits ? DIM_BITS'(trial - {1'b0, div_q}) : trial[DIM_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(NODE_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			// shift the dividend out, the quotient bit in
			quot_q <= {quot_q[NODE_BITS-2:0], fits};
			rem_q  <= rem_next;
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/gne_cost.sv =====
// Edge cost unit: registered diagonal multiply, then rounding and saturation; straight edges pass the registered base.
module gne_cost
	import gne_pkg::*;
(
	input  logic                   clk,
	input  logic                   load,
	input  logic [WEIGHT_BITS-1:0] base,
	input  logic [FACTOR_BITS-1:0] factor,
	input  logic                   diag,
	output logic [COST_BITS-1:0]   cost
);

	logic [PROD_BITS-1:0]   prod_q;
	logic [WEIGHT_BITS-1:0] base_q;
	logic                   diag_q;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PROD_BITS'(base) * PROD_BITS'(factor);
			base_q <= base;
			diag_q <= diag;
		end
	end

	assign cost = diag_q ? round_cost(prod_q) : COST_BITS'(base_q);

endmodule

// ===== hw/rtl/grid_neighbor_expansion.sv =====
// Write request: accepted while idle, no result, ready again the next cycle.
// Expand request: node split by a bit-serial divider, then each of the eight
// directions is skipped or has its cell read from the single store read port;
// the results it emits can be held up by output stalls.
// Out-of-range requests go straight to the finish state, which registers their empty result once the output is free.
// Reset clears control state and restores register defaults; the store is not cleared.
module grid_neighbor_expansion
	import gne_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  req_t                     req,
	output logic                     res_valid,
	input  logic                     res_ready,
	output res_t                     res,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_DIR,
		ST_RD,
		ST_EMIT,
		ST_FINISH
	} state_t;

	// configuration registers
	logic [DIM_BITS-1:0]    grid_width_q;
	logic [DIM_BITS-1:0]    grid_height_q;
	logic [MODE_BITS-1:0]   diag_mode_q;
	logic                   wrap_h_q;
	logic                   wrap_v_q;
	logic [FACTOR_BITS-1:0] diag_factor_q;

	state_t                 state_q;
	logic [DIR_BITS-1:0]    dir_q;
	logic [3:0]             given_q;
	logic                   rev_q;
	logic [X_BITS-1:0]      x_q;
	logic [Y_BITS-1:0]      y_q;
	logic [WEIGHT_BITS-1:0] src_weight_q;
	logic [ADDR_BITS-1:0]   nb_q;
	res_t                   hold_q;
	logic                   hold_valid_q;
	res_t                   res_q;
	logic                   res_valid_q;

	logic [DIM_BITS-1:0]     grid_w;
	logic [DIM_BITS-1:0]     grid_h;
	logic [2*DIM_BITS-1:0]   area;
	logic                    out_of_range;
	logic                    req_take;
	logic                    res_free;
	logic                    last_dir;

	logic signed [1:0]            dx;
	logic signed [1:0]            dy;
	logic signed [COORD_BITS-1:0] w_s;
	logic signed [COORD_BITS-1:0] h_s;
	logic signed [COORD_BITS-1:0] nx;
	logic signed [COORD_BITS-1:0] ny;
	logic signed [COORD_BITS-1:0] nx_w;
	logic signed [COORD_BITS-1:0] ny_w;
	logic                         in_bounds;
	logic                         vert_given;
	logic                         horiz_given;
	logic                         gate;
	logic                         take;
	logic [ADDR_BITS-1:0]         nb_id;

	logic                   st_we;
	logic                   st_re;
	logic [ADDR_BITS-1:0]   st_raddr;
	logic [ENTRY_BITS-1:0]  st_rdata;
	logic                   rd_blocked;
	logic [WEIGHT_BITS-1:0] rd_weight;

	logic                   div_busy;
	logic [NODE_BITS-1:0]   div_quot;
	logic [DIM_BITS-1:0]    div_rem;

	logic                   cost_load;
	logic [WEIGHT_BITS-1:0] cost_base;
	logic [COST_BITS-1:0]   cost;

	assign grid_w = (grid_width_q == '0) ? DIM_BITS'(1) :
		(grid_width_q > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : grid_width_q;
	assign grid_h = (grid_height_q == '0) ? DIM_BITS'(1) :
		(grid_height_q > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : grid_height_q;
	assign area         = (2*DIM_BITS)'(grid_w) * (2*DIM_BITS)'(grid_h);
	assign out_of_range = (2*DIM_BITS)'(req.node) >= area;

	assign req_ready = (state_q == ST_IDLE);
	assign req_take  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign res_free  = !res_valid_q || res_ready;
	assign last_dir  = (dir_q == DIR_BITS'(NUM_DIRS - 1));

	// neighbor coordinates, wrapping, bounds and diagonal gating for the current direction
	always_comb begin
		dx   = step_dx(dir_q);
		dy   = step_dy(dir_q);
		w_s  = $signed(COORD_BITS'(grid_w));
		h_s  = $signed(COORD_BITS'(grid_h));
		nx   = $signed(COORD_BITS'(x_q)) + COORD_BITS'(dx);
		ny   = $signed(COORD_BITS'(y_q)) + COORD_BITS'(dy);
		nx_w = nx;
		ny_w = ny;
		if (wrap_h_q && nx < 0) begin
			nx_w = nx + w_s;
		end else if (wrap_h_q && nx >= w_s) begin
			nx_w = nx - w_s;
		end
		if (wrap_v_q && ny < 0) begin
			ny_w = ny + h_s;
		end else if (wrap_v_q && ny >= h_s) begin
			ny_w = ny - h_s;
		end
		in_bounds = (nx_w >= 0) && (nx_w < w_s) && (ny_w >= 0) && (ny_w < h_s);
		nb_id = ADDR_BITS'(ny_w[Y_BITS-1:0]) * ADDR_BITS'(grid_w)
			+ ADDR_BITS'(nx_w[X_BITS-1:0]);

		vert_given  = dir_q[1] ? given_q[1] : given_q[0];
		horiz_given = dir_q[0] ? given_q[3] : given_q[2];
		if (!dir_q[2]) begin
			gate = 1'b1;
		end else begin
			unique case (diag_mode_q)
				DIAG_NONE:   gate = 1'b0;
				DIAG_BOTH:   gate = vert_given && horiz_given;
				DIAG_EITHER: gate = vert_given || horiz_given;
				DIAG_ALWAYS: gate = 1'b1;
				default:     gate = 1'b0;
			endcase
		end
		take = in_bounds && gate;
	end

	assign st_we    = req_take && (req.op == OP_WRITE);
	assign st_re    = (req_take && (req.op == OP_EXPAND)) || ((state_q == ST_DIR) && take);
	assign st_raddr = (state_q == ST_DIR) ? nb_id : ADDR_BITS'(req.node);

	assign rd_blocked = st_rdata[ENTRY_BITS-1];
	assign rd_weight  = st_rdata[WEIGHT_BITS-1:0];

	assign cost_load = (state_q == ST_RD);
	assign cost_base = rev_q ? src_weight_q : rd_weight;

	gne_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (ADDR_BITS'(req.node)),
		.wdata ({req.obstacle_in, req.weight_in[WEIGHT_BITS-1:0]}),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	gne_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_take && (req.op == OP_EXPAND) && !out_of_range),
		.dividend (req.node),
		.divisor  (grid_w),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	gne_cost u_cost (
		.clk    (clk),
		.load   (cost_load),
		.base   (cost_base),
		.factor (diag_factor_q),
		.diag   (dir_q[2]),
		.cost   (cost)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_BITS'(64);
			grid_height_q <= DIM_BITS'(64);
			diag_mode_q   <= DIAG_NONE;
			wrap_h_q      <= 1'b0;
			wrap_v_q      <= 1'b0;
			diag_factor_q <= FACTOR_BITS'(362);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:    grid_width_q  <= cfg_data[DIM_BITS-1:0];
				CFG_GRID_HEIGHT:   grid_height_q <= cfg_data[DIM_BITS-1:0];
				CFG_DIAGONAL_MODE: diag_mode_q   <= cfg_data[MODE_BITS-1:0];
				CFG_WRAP_HORIZ:    wrap_h_q      <= cfg_data[0];
				CFG_WRAP_VERT:     wrap_v_q      <= cfg_data[0];
				CFG_DIAG_FACTOR:   diag_factor_q <= cfg_data[FACTOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dir_q        <= '0;
			given_q      <= '0;
			rev_q        <= 1'b0;
			x_q          <= '0;
			y_q          <= '0;
			src_weight_q <= '0;
			nb_q         <= '0;
			hold_q       <= '0;
			hold_valid_q <= 1'b0;
			res_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take && (req.op == OP_EXPAND)) begin
						given_q      <= '0;
						hold_valid_q <= 1'b0;
						dir_q        <= '0;
						rev_q        <= req.reversed;
						state_q      <= out_of_range ? ST_FINISH : ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						x_q          <= div_rem[X_BITS-1:0];
						y_q          <= div_quot[Y_BITS-1:0];
						src_weight_q <= rd_weight;
						state_q      <= rd_blocked ? ST_FINISH : ST_DIR;
					end
				end
				ST_DIR: begin
					if (take) begin
						nb_q    <= nb_id;
						state_q <= ST_RD;
					end else if (last_dir) begin
						state_q <= ST_FINISH;
					end else begin
						dir_q <= dir_q + 1'b1;
					end
				end
				ST_RD: begin
					if (!rd_blocked) begin
						if (!dir_q[2]) begin
							given_q[dir_q[1:0]] <= 1'b1;
						end
						state_q <= ST_EMIT;
					end else if (last_dir) begin
						state_q <= ST_FINISH;
					end else begin
						dir_q   <= dir_q + 1'b1;
						state_q <= ST_DIR;
					end
				end
				ST_EMIT: begin
					// keep one result in hand so the final one can carry last
					if (!hold_valid_q || res_free) begin
						if (hold_valid_q) begin
							res_q       <= hold_q;
							res_valid_q <= 1'b1;
						end
						hold_q       <= '{neighbor: NODE_BITS'(nb_q), edge_cost: cost,
							empty_res: 1'b0, last: 1'b0};
						hold_valid_q <= 1'b1;
						if (last_dir) begin
							state_q <= ST_FINISH;
						end else begin
							dir_q   <= dir_q + 1'b1;
							state_q <= ST_DIR;
						end
					end
				end
				ST_FINISH: begin
					if (res_free) begin
						if (hold_valid_q) begin
							res_q <= '{neighbor: hold_q.neighbor, edge_cost: hold_q.edge_cost,
								empty_res: 1'b0, last: 1'b1};
						end else begin
							res_q <= '{neighbor: '0, edge_cost: '0, empty_res: 1'b1, last: 1'b1};
						end
						res_valid_q  <= 1'b1;
						hold_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hw/rtl/gne_checker.sv =====
// Port-level checks for the grid neighbor expansion block, bound to the top level.
module gne_checker
	import gne_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input req_t                     req,
	input logic                     res_valid,
	input logic                     res_ready,
	input res_t                     res,
	input logic                     cfg_valid,
	input logic                     cfg_ready,
	input logic [CFG_IDX_BITS-1:0]  cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.empty_res |-> res.last && res.neighbor == '0 && res.edge_cost == '0)
		else $error("empty result malformed");

	a_expand_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.op == OP_EXPAND |=> !req_ready)
		else $error("ready right after expand request");

	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.op == OP_WRITE |=> req_ready)
		else $error("write request stalled the block");

endmodule

bind grid_neighbor_expansion gne_checker u_gne_checker (.*);
